// File: hw/rtl/first_fit_word_allocator_assert.svh
`ifndef FIRST_FIT_WORD_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_WORD_ALLOCATOR_ASSERT_SVH

// check on every clock edge outside reset
`define FFWA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// check on every clock edge, reset included
`define FFWA_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hw/rtl/ffwa_pkg.sv
package ffwa_pkg;

  localparam int WORDS     = 1024;
  localparam int DATA_BITS = 32;
  localparam int POS_W     = $clog2(WORDS);
  localparam int ACT_W     = 2;
  localparam int LEN_W     = 11;
  localparam int ADDR_W    = 10;
  localparam int VAL_W     = 32;
  localparam int CMP_W     = LEN_W + 1;

  typedef enum logic [ACT_W-1:0] {
    ACT_ALLOC = 2'd0,
    ACT_WRITE = 2'd1,
    ACT_FREE  = 2'd2,
    ACT_READ  = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_MARK,
    ST_SWEEP,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic shift;
    logic din;
  } chain_t;

endpackage

// File: hw/rtl/ffwa_cell.sv
module ffwa_cell (
  input  logic clk,
  input  logic rst,
  input  logic shift,
  input  logic din,
  output logic q
);

  always_ff @(posedge clk) begin
    if (rst) begin
      q <= 1'b0;
    end else if (shift) begin
      q <= din;
    end
  end

endmodule

// File: hw/rtl/ffwa_ctrl.sv
`include "first_fit_word_allocator_assert.svh"

module ffwa_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [ffwa_pkg::ACT_W-1:0]    action,
  input  logic [ffwa_pkg::LEN_W-1:0]    length,
  input  logic [ffwa_pkg::ADDR_W-1:0]   address,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          status,
  output logic [ffwa_pkg::POS_W-1:0]    run_start,
  output logic [ffwa_pkg::VAL_W-1:0]    read_value,
  output logic                          read_used,
  input  logic                          head,
  input  logic [ffwa_pkg::DATA_BITS-1:0] rd_data,
  output ffwa_pkg::chain_t              chain
);

  import ffwa_pkg::*;

  state_t               state, state_next;
  logic [POS_W-1:0]     pos;
  action_t              op;
  logic [LEN_W-1:0]     len;
  logic [ADDR_W-1:0]    addr;
  logic [LEN_W-1:0]     run;
  logic                 found;
  logic [POS_W-1:0]     start;
  logic                 used_seen;

  logic                 accept;
  logic                 load;
  logic                 last;
  logic                 hit;
  logic                 addr_ok;
  logic                 in_range;
  logic [LEN_W-1:0]     run_inc;
  logic [CMP_W-1:0]     pos_ext;
  logic [CMP_W-1:0]     addr_ext;
  logic [CMP_W-1:0]     lo;
  logic [CMP_W-1:0]     hi;
  logic [CMP_W-1:0]     start_sum;

  assign accept    = in_valid && in_ready;
  assign last      = (pos == POS_W'(WORDS - 1));
  assign run_inc   = run + LEN_W'(1);
  assign pos_ext   = CMP_W'(pos);
  assign addr_ext  = CMP_W'(addr);
  assign addr_ok   = addr_ext < CMP_W'(WORDS);
  assign hit       = (state == ST_SCAN) && !found && !head && (run_inc == len);
  assign start_sum = pos_ext + CMP_W'(1) - CMP_W'(len);
  assign lo        = (state == ST_MARK) ? CMP_W'(start) : addr_ext;
  assign hi        = lo + CMP_W'(len);
  assign in_range  = (pos_ext >= lo) && (pos_ext < hi);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (action_t'(action) == ACT_ALLOC) begin
            state_next = (length == '0) ? ST_FINISH : ST_SCAN;
          end else begin
            state_next = ST_SWEEP;
          end
        end
      end
      ST_SCAN: begin
        if (last) begin
          state_next = (found || hit) ? ST_MARK : ST_FINISH;
        end
      end
      ST_MARK, ST_SWEEP: begin
        if (last) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (load) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready    = (state == ST_IDLE);
    chain.shift = (state == ST_SCAN) || (state == ST_MARK) || (state == ST_SWEEP);
    load        = (state == ST_FINISH) && (!out_valid || out_ready);
    chain.din   = head;
    case (state)
      ST_MARK: chain.din = head | in_range;
      ST_SWEEP: begin
        case (op)
          ACT_FREE:  chain.din = head & ~in_range;
          ACT_WRITE: chain.din = head | (addr_ok && (pos_ext == addr_ext));
          default:   chain.din = head;
        endcase
      end
      default: chain.din = head;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      pos       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (chain.shift) begin
        pos <= last ? '0 : pos + POS_W'(1);
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op        <= action_t'(action);
      len       <= length;
      addr      <= address;
      run       <= '0;
      found     <= (length == '0);
      start     <= '0;
      used_seen <= 1'b0;
    end
    if (state == ST_SCAN && !found) begin
      run <= head ? '0 : run_inc;
      if (hit) begin
        found <= 1'b1;
        start <= start_sum[POS_W-1:0];
      end
    end
    if (state == ST_SWEEP && pos_ext == addr_ext) begin
      used_seen <= head;
    end
    if (load) begin
      status     <= (op == ACT_ALLOC) && !found;
      run_start  <= ((op == ACT_ALLOC) && found) ? start : '0;
      read_value <= ((op == ACT_READ) && addr_ok) ? VAL_W'(rd_data) : '0;
      read_used  <= (op == ACT_READ) && addr_ok && used_seen;
    end
  end

  `FFWA_ASSERT(a_ring_aligned, (state == ST_IDLE) |-> (pos == '0), "ring not aligned at idle")
  `FFWA_ASSERT(a_leave_idle, accept |=> (state != ST_IDLE), "item accepted but block idle")
  `FFWA_ASSERT(a_mark_found, (state == ST_MARK) |-> found, "marking without a found run")
  `FFWA_ASSERT(a_fail_start, (out_valid && status) |-> (run_start == '0), "failed run start")
  `FFWA_ASSERT_ALWAYS(a_reset_out, rst |=> !out_valid, "result valid after reset")

endmodule

// File: hw/rtl/first_fit_word_allocator.sv
// Write, free and read make one sweep of the use-map ring between accept and result.
// Allocation that finds a run makes a scan and then a mark rotation, a failed one only
// the scan, and an allocation of length zero goes to the result with no rotation.
// The block takes one item at a time, set by full rotations of the WORDS-cell use-map ring.
// Reset clears the whole use map, the state, the ring position and the result valid flag;
// the word store holds no defined value until written.
module first_fit_word_allocator (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [ffwa_pkg::ACT_W-1:0]    action,
  input  logic [ffwa_pkg::LEN_W-1:0]    length,
  input  logic [ffwa_pkg::ADDR_W-1:0]   address,
  input  logic signed [ffwa_pkg::VAL_W-1:0] value,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          status,
  output logic [ffwa_pkg::POS_W-1:0]    run_start,
  output logic signed [ffwa_pkg::VAL_W-1:0] read_value,
  output logic                          read_used
);

  import ffwa_pkg::*;

  logic [DATA_BITS-1:0] mem [WORDS];
  logic [DATA_BITS-1:0] rd_data;
  logic [WORDS-1:0]     use_q;
  logic [VAL_W-1:0]     read_bits;
  logic                 accept;
  logic                 addr_ok;
  chain_t               chain;

  assign accept     = in_valid && in_ready;
  assign addr_ok    = CMP_W'(address) < CMP_W'(WORDS);
  assign read_value = read_bits;

  always_ff @(posedge clk) begin
    if (accept && addr_ok && action_t'(action) == ACT_WRITE) begin
      mem[address[POS_W-1:0]] <= value[DATA_BITS-1:0];
    end
    if (accept && addr_ok && action_t'(action) == ACT_READ) begin
      rd_data <= mem[address[POS_W-1:0]];
    end
  end

  for (genvar k = 0; k < WORDS; k++) begin : g_ring
    if (k == WORDS - 1) begin : g_tail
      ffwa_cell u_cell (
        .clk   (clk),
        .rst   (rst),
        .shift (chain.shift),
        .din   (chain.din),
        .q     (use_q[k])
      );
    end else begin : g_body
      ffwa_cell u_cell (
        .clk   (clk),
        .rst   (rst),
        .shift (chain.shift),
        .din   (use_q[k+1]),
        .q     (use_q[k])
      );
    end
  end

  ffwa_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .action     (action),
    .length     (length),
    .address    (address),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .status     (status),
    .run_start  (run_start),
    .read_value (read_bits),
    .read_used  (read_used),
    .head       (use_q[0]),
    .rd_data    (rd_data),
    .chain      (chain)
  );

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 100ps

module tb;
  import ffwa_pkg::*;

  localparam int LIMIT_CYCLES = 4_000_000;
  localparam int SETTLE_CYCLES = 2 * WORDS + 16;
  localparam int RANDOM_ITEMS = 560;

  typedef struct packed {
    logic status;
    logic [POS_W-1:0] run_start;
    logic signed [VAL_W-1:0] read_value;
    logic read_used;
  } alloc_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [ACT_W-1:0] action = ACT_ALLOC;
  logic [LEN_W-1:0] length = '0;
  logic [ADDR_W-1:0] address = '0;
  logic signed [VAL_W-1:0] value = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic status;
  logic [POS_W-1:0] run_start;
  logic signed [VAL_W-1:0] read_value;
  logic read_used;

  logic [WORDS-1:0] used_words = '0;
  logic [DATA_BITS-1:0] stored_words [WORDS];
  logic [WORDS-1:0] written_words = '0;
  int written_addrs[$];
  int live_run_start[$];
  int live_run_len[$];
  alloc_result_t expected_results[$];

  int unsigned cycle_count = 0;
  int mismatches = 0;
  int item_count = 0;
  int n_alloc = 0;
  int n_alloc_fail = 0;
  int n_write = 0;
  int n_free = 0;
  int n_read = 0;
  bit steady = 1'b0;

  first_fit_word_allocator dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .action(action),
    .length(length),
    .address(address),
    .value(value),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .status(status),
    .run_start(run_start),
    .read_value(read_value),
    .read_used(read_used)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  always @(negedge clk) begin
    out_ready <= steady || ($urandom_range(99) >= 23);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("first_fit_word_allocator regression: fail");
      $finish;
    end
  end

  function automatic alloc_result_t predict_result(action_t act, logic [LEN_W-1:0] len,
                                                   logic [ADDR_W-1:0] addr,
                                                   logic signed [VAL_W-1:0] val);
    alloc_result_t r;
    int run;
    int i;
    int a;
    r = '0;
    case (act)
      ACT_ALLOC: begin
        run = 0;
        i = 0;
        while (i < WORDS && run < int'(len)) begin
          if (!used_words[POS_W'(i)]) run++;
          else run = 0;
          i++;
        end
        if (run < int'(len)) begin
          r.status = 1'b1;
        end else begin
          for (a = i - int'(len); a < i; a++) used_words[POS_W'(a)] = 1'b1;
          r.run_start = POS_W'(i - int'(len));
        end
      end
      ACT_WRITE: begin
        if (int'(addr) < WORDS) begin
          stored_words[addr] = val[DATA_BITS-1:0];
          used_words[addr] = 1'b1;
        end
      end
      ACT_FREE: begin
        for (a = int'(addr); a < int'(addr) + int'(len) && a < WORDS; a++)
          used_words[POS_W'(a)] = 1'b0;
      end
      default: begin
        if (int'(addr) < WORDS) begin
          r.read_value = stored_words[addr];
          r.read_used = used_words[addr];
        end
      end
    endcase
    return r;
  endfunction

  always @(posedge clk) begin : check_result
    alloc_result_t got;
    alloc_result_t want;
    if (!rst && out_valid && out_ready) begin
      got = '{status, run_start, read_value, read_used};
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: status=%0d run_start=%0d read_value=%0d read_used=%0d",
                   got.status, got.run_start, got.read_value, got.read_used);
      end else begin
        want = expected_results.pop_front();
        if (got.status !== want.status || got.run_start !== want.run_start ||
            got.read_value !== want.read_value || got.read_used !== want.read_used) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp status=%0d run_start=%0d read_value=%0d read_used=%0d",
                     want.status, want.run_start, want.read_value, want.read_used,
                     " got status=%0d run_start=%0d read_value=%0d read_used=%0d",
                     got.status, got.run_start, got.read_value, got.read_used);
        end
      end
    end
  end

  task automatic issue_item(input action_t act, input int len, input int addr,
                            input logic signed [VAL_W-1:0] val, output alloc_result_t r);
    @(negedge clk);
    if (!steady) begin
      while ($urandom_range(99) < 23) begin
        in_valid <= 1'b0;
        @(negedge clk);
      end
    end
    action <= act;
    length <= LEN_W'(len);
    address <= ADDR_W'(addr);
    value <= val;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    r = predict_result(act, LEN_W'(len), ADDR_W'(addr), val);
    expected_results.push_back(r);
    item_count++;
    case (act)
      ACT_ALLOC: begin
        n_alloc++;
        if (r.status) n_alloc_fail++;
        else if (len > 0) begin
          live_run_start.push_back(int'(r.run_start));
          live_run_len.push_back(len);
        end
      end
      ACT_WRITE: begin
        n_write++;
        if (!written_words[POS_W'(addr)]) begin
          written_words[POS_W'(addr)] = 1'b1;
          written_addrs.push_back(addr);
        end
      end
      ACT_FREE: n_free++;
      default: n_read++;
    endcase
  endtask

  task automatic send(input action_t act, input int len, input int addr,
                      input logic signed [VAL_W-1:0] val);
    alloc_result_t r;
    issue_item(act, len, addr, val, r);
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic test_alloc_limits();
    send(ACT_ALLOC, 0, 0, 0);
    send(ACT_ALLOC, 2047, 0, 0);
    send(ACT_ALLOC, WORDS + 1, 0, 0);
    send(ACT_ALLOC, WORDS, 0, 0);
    send(ACT_ALLOC, 1, 0, 0);
    send(ACT_FREE, WORDS, 0, 0);
  endtask

  task automatic test_store_extremes();
    send(ACT_WRITE, 0, 0, 32'sh8000_0000);
    send(ACT_WRITE, 0, WORDS - 1, 32'sh7fff_ffff);
    send(ACT_WRITE, 0, 512, 0);
    send(ACT_WRITE, 0, 341, -1);
    send(ACT_READ, 0, 0, 0);
    send(ACT_READ, 0, WORDS - 1, 0);
    send(ACT_READ, 0, 512, 0);
    send(ACT_READ, 0, 341, 0);
  endtask

  task automatic test_free_past_end();
    send(ACT_FREE, 2047, WORDS - 1, 0);
    send(ACT_READ, 0, WORDS - 1, 0);
    send(ACT_FREE, 0, 0, 0);
    send(ACT_READ, 0, 0, 0);
  endtask

  task automatic test_first_fit();
    send(ACT_ALLOC, 340, 0, 0);
    send(ACT_ALLOC, 5, 0, 0);
    send(ACT_ALLOC, 700, 0, 0);
    send(ACT_ALLOC, 511, 0, 0);
    send(ACT_FREE, 340, 1, 0);
    send(ACT_ALLOC, 2, 0, 0);
  endtask

  function automatic logic signed [VAL_W-1:0] random_word();
    case ($urandom_range(9))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return -1;
      3: return 0;
      default: return $urandom;
    endcase
  endfunction

  task automatic test_random_mix();
    alloc_result_t r;
    int target;
    int pick;
    int len;
    int k;
    int idx;
    int offs;
    bit drained;
    target = item_count + RANDOM_ITEMS;
    drained = 1'b0;
    while (item_count < target) begin
      steady = (item_count >= target - 400) && (item_count < target - 300);
      if (!drained && item_count >= target - 150) begin
        drained = 1'b1;
        drain_results();
      end
      pick = $urandom_range(99);
      if (pick < 20) begin
        len = ($urandom_range(14) == 0) ? $urandom_range(WORDS) : $urandom_range(1, 24);
        issue_item(ACT_ALLOC, len, 0, 0, r);
        if (!r.status && len > 0) begin
          for (k = $urandom_range(3); k > 0; k--) begin
            offs = $urandom_range(len - 1);
            send(ACT_WRITE, 0, r.run_start + offs, random_word());
            send(ACT_READ, 0, r.run_start + offs, 0);
          end
        end
      end else if (pick < 32) begin
        if (live_run_start.size() > 0) begin
          idx = $urandom_range(live_run_start.size() - 1);
          send(ACT_FREE, live_run_len[idx], live_run_start[idx], 0);
          live_run_start.delete(idx);
          live_run_len.delete(idx);
        end else begin
          send(ACT_FREE, $urandom_range(64), $urandom_range(WORDS - 1), 0);
        end
      end else if (pick < 55) begin
        send(ACT_WRITE, $urandom_range(WORDS), $urandom_range(WORDS - 1), random_word());
      end else if (pick < 88) begin
        idx = $urandom_range(written_addrs.size() - 1);
        send(ACT_READ, $urandom_range(WORDS), written_addrs[idx], $urandom);
      end else begin
        len = ($urandom_range(9) == 0) ? $urandom_range(WORDS) : $urandom_range(64);
        send(ACT_FREE, len, $urandom_range(WORDS - 1), $urandom);
      end
    end
    steady = 1'b0;
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_alloc_limits();
    test_store_extremes();
    test_free_past_end();
    test_first_fit();
    drain_results();
    test_random_mix();
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("covered %0d items: %0d allocations (%0d without room), %0d writes,",
             item_count, n_alloc, n_alloc_fail, n_write);
    $display("  %0d frees and %0d reads in %0d cycles, %0d mismatching results",
             n_free, n_read, cycle_count, mismatches);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("first_fit_word_allocator regression: pass");
    end else begin
      $display("first_fit_word_allocator regression: fail");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+hw/rtl
hw/rtl/ffwa_pkg.sv
hw/rtl/ffwa_cell.sv
hw/rtl/ffwa_ctrl.sv
hw/rtl/first_fit_word_allocator.sv
tb/sv/tb.sv
